FILE: sv/sda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sda_pkg
// Shared widths, constants and register indexes of the distance attenuation.
// ----------------------------------------------------------------------------
package sda_pkg;

    localparam int DIST_W    = 25;
    localparam int GAIN_W    = 16;
    localparam int QUOT_W    = 15;
    localparam int CFG_IDX_W = 3;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd32768;
    localparam logic [DIST_W-1:0] DIST_MAX = 25'h1FFFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_LISTENER_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LISTENER_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LISTENER_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FALLOFF     = 3'd3;

    typedef enum logic [1:0] {
        MODEL_NONE     = 2'd0,
        MODEL_INVERSE  = 2'd1,
        MODEL_LINEAR   = 2'd2,
        MODEL_EXPONENT = 2'd3
    } model_t;

    function automatic logic [GAIN_W-1:0] sat_gain(input logic [GAIN_W-1:0] v);
        return (v > GAIN_ONE) ? GAIN_ONE : v;
    endfunction

endpackage

FILE: sv/sda_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sda_sqrt
// Pipelined floor square root, one radicand bit pair per stage.
// ----------------------------------------------------------------------------
module sda_sqrt #(
    parameter int IN_W = 50,
    parameter int SB_W = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [IN_W-1:0]     radicand,
    input  logic [SB_W-1:0]     in_sb,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   root,
    output logic [SB_W-1:0]     out_sb
);
    localparam int NS  = IN_W / 2;
    localparam int RTW = IN_W / 2;
    localparam int RW  = RTW + 2;

    logic               valid_reg [1:NS];
    logic [IN_W-1:0]    rad_reg   [1:NS];
    logic [RW-1:0]      rem_reg   [1:NS];
    logic [RTW-1:0]     root_reg  [1:NS];
    logic [SB_W-1:0]    sb_reg    [1:NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic            v_cur;
        logic [IN_W-1:0] rad_cur;
        logic [RW-1:0]   rem_cur;
        logic [RTW-1:0]  root_cur;
        logic [SB_W-1:0] sb_cur;
        logic [RW-1:0]   rem_s;
        logic [RW-1:0]   trial;
        logic            ge;
        logic [RW-1:0]   rem_next;
        logic [RTW-1:0]  root_next;

        if (k == 0) begin : g_head
            assign v_cur    = in_valid;
            assign rad_cur  = radicand;
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign sb_cur   = in_sb;
        end
        else begin : g_tail
            assign v_cur    = valid_reg[k];
            assign rad_cur  = rad_reg[k];
            assign rem_cur  = rem_reg[k];
            assign root_cur = root_reg[k];
            assign sb_cur   = sb_reg[k];
        end

        always_comb
        begin
            rem_s     = {rem_cur[RW-3:0], rad_cur[IN_W-1 -: 2]};
            trial     = {root_cur, 2'b01};
            ge        = (rem_s >= trial);
            rem_next  = ge ? (rem_s - trial) : rem_s;
            root_next = {root_cur[RTW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                valid_reg[k+1] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[k+1]  <= {rad_cur[IN_W-3:0], 2'b00};
            rem_reg[k+1]  <= rem_next;
            root_reg[k+1] <= root_next;
            sb_reg[k+1]   <= sb_cur;
        end
    end

    assign out_valid = valid_reg[NS];
    assign root      = root_reg[NS];
    assign out_sb    = sb_reg[NS];

endmodule

FILE: sv/sda_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sda_div
// Pipelined restoring divider of base * 2^QW by a larger divisor.
// ----------------------------------------------------------------------------
module sda_div #(
    parameter int DW   = 25,
    parameter int QW   = 15,
    parameter int SB_W = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [DW-1:0]   base,
    input  logic [DW-1:0]   divisor,
    input  logic [SB_W-1:0] in_sb,
    output logic            out_valid,
    output logic [QW-1:0]   quotient,
    output logic [SB_W-1:0] out_sb
);
    logic               valid_reg [1:QW];
    logic [DW-1:0]      rem_reg   [1:QW];
    logic [DW-1:0]      den_reg   [1:QW];
    logic [QW-1:0]      q_reg     [1:QW];
    logic [SB_W-1:0]    sb_reg    [1:QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic            v_cur;
        logic [DW-1:0]   rem_cur;
        logic [DW-1:0]   den_cur;
        logic [QW-1:0]   q_cur;
        logic [SB_W-1:0] sb_cur;
        logic [DW:0]     r2;
        logic            ge;
        logic [DW:0]     r_next;

        if (k == 0) begin : g_head
            assign v_cur   = in_valid;
            assign rem_cur = base;
            assign den_cur = divisor;
            assign q_cur   = '0;
            assign sb_cur  = in_sb;
        end
        else begin : g_tail
            assign v_cur   = valid_reg[k];
            assign rem_cur = rem_reg[k];
            assign den_cur = den_reg[k];
            assign q_cur   = q_reg[k];
            assign sb_cur  = sb_reg[k];
        end

        always_comb
        begin
            r2     = {rem_cur, 1'b0};
            ge     = (r2 >= {1'b0, den_cur});
            r_next = ge ? (r2 - {1'b0, den_cur}) : r2;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                valid_reg[k+1] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= r_next[DW-1:0];
            den_reg[k+1] <= den_cur;
            q_reg[k+1]   <= {q_cur[QW-2:0], ge};
            sb_reg[k+1]  <= sb_cur;
        end
    end

    assign out_valid = valid_reg[QW];
    assign quotient  = q_reg[QW];
    assign out_sb    = sb_reg[QW];

endmodule

FILE: sv/source_distance_attenuation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_distance_attenuation
// Listener distance, falloff gain and final volume of one sound source.
// ----------------------------------------------------------------------------
// channel  | handshake                  | beat
// input    | start, busy                | pos_x..z, near/far, volume, occlusion
// config   | cfg_valid, cfg_ready       | cfg_index, cfg_data
// result   | result_valid (strobe)      | distance_out, attenuation, final_volume
//
// One beat accepted per cycle; busy stays low and cfg_ready stays high.
// The pipeline has three front stages, COORD_WIDTH + 1 square root stages,
// one compare stage, 15 divider stages and two multiplier stages.
// Reset clears the valid bits and sets the config registers to their reset values.
// The receiver cannot stall, so the pipeline advances every cycle.
// ----------------------------------------------------------------------------
module source_distance_attenuation #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [COORD_WIDTH-1:0]     pos_x,
    input  logic signed [COORD_WIDTH-1:0]     pos_y,
    input  logic signed [COORD_WIDTH-1:0]     pos_z,
    input  logic [sda_pkg::DIST_W-1:0]        near_distance,
    input  logic [sda_pkg::DIST_W-1:0]        far_distance,
    input  logic [sda_pkg::GAIN_W-1:0]        source_volume,
    input  logic                              occlusion_on,
    input  logic [sda_pkg::GAIN_W-1:0]        occlusion_gain,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sda_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [COORD_WIDTH-1:0]            cfg_data,
    output logic                              result_valid,
    output logic [sda_pkg::DIST_W-1:0]        distance_out,
    output logic [sda_pkg::GAIN_W-1:0]        attenuation,
    output logic [sda_pkg::GAIN_W-1:0]        final_volume
);
    import sda_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int SQW  = 2 * W + 2;
    localparam int RTW  = W + 1;
    localparam int CMPW = (RTW > DIST_W) ? RTW : DIST_W;
    localparam int SB1  = 2 * DIST_W + 2 * GAIN_W;
    localparam int SB2  = DIST_W + 1 + 3 * GAIN_W;
    localparam logic [W-1:0] SIGN_BIT = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0]  lx_reg, ly_reg, lz_reg;
    model_t        model_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lx_reg    <= '0;
            ly_reg    <= '0;
            lz_reg    <= '0;
            model_reg <= MODEL_INVERSE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LISTENER_X: lx_reg <= cfg_data;
                REG_LISTENER_Y: ly_reg <= cfg_data;
                REG_LISTENER_Z: lz_reg <= cfg_data;
                REG_FALLOFF:    model_reg <= model_t'(cfg_data[1:0]);
                default:        ;
            endcase
        end
    end

    function automatic logic [W-1:0] abs_diff(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W-1:0] x;
        logic [W-1:0] y;
        x = a ^ SIGN_BIT;
        y = b ^ SIGN_BIT;
        return (x >= y) ? (x - y) : (y - x);
    endfunction

    // front: differences, squares, sum
    logic [2:0]       v_reg;
    logic [W-1:0]     dx_reg, dy_reg, dz_reg;
    logic [2*W-1:0]   sx_reg, sy_reg, sz_reg;
    logic [SQW-1:0]   sum_reg;
    logic [SB1-1:0]   sb_a_reg, sb_b_reg, sb_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[1:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg   <= abs_diff(pos_x, lx_reg);
        dy_reg   <= abs_diff(pos_y, ly_reg);
        dz_reg   <= abs_diff(pos_z, lz_reg);
        sb_a_reg <= {near_distance, far_distance, sat_gain(source_volume),
                     occlusion_on ? sat_gain(occlusion_gain) : GAIN_ONE};
        sx_reg   <= dx_reg * dx_reg;
        sy_reg   <= dy_reg * dy_reg;
        sz_reg   <= dz_reg * dz_reg;
        sb_b_reg <= sb_a_reg;
        sum_reg  <= {2'b00, sx_reg} + {2'b00, sy_reg} + {2'b00, sz_reg};
        sb_c_reg <= sb_b_reg;
    end

    logic             sq_valid;
    logic [RTW-1:0]   d_root;
    logic [SB1-1:0]   sq_sb;

    sda_sqrt #(.IN_W(SQW), .SB_W(SB1)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_reg[2]),
        .radicand  (sum_reg),
        .in_sb     (sb_c_reg),
        .out_valid (sq_valid),
        .root      (d_root),
        .out_sb    (sq_sb)
    );

    // compare and divider setup
    logic [DIST_W-1:0] q_near, q_far;
    logic [GAIN_W-1:0] q_vol, q_occ;
    logic [CMPW-1:0]   d_ext, near_ext, far_ext;
    logic [DIST_W-1:0] d_sat;
    logic              fixed;
    logic [GAIN_W-1:0] fixed_gain;
    logic [DIST_W-1:0] dv_base, dv_den;

    always_comb
    begin
        {q_near, q_far, q_vol, q_occ} = sq_sb;
        d_ext    = CMPW'(d_root);
        near_ext = CMPW'(q_near);
        far_ext  = CMPW'(q_far);
        d_sat    = (d_ext > CMPW'(DIST_MAX)) ? DIST_MAX : d_ext[DIST_W-1:0];
        fixed      = 1'b1;
        fixed_gain = GAIN_ONE;
        dv_base    = q_near;
        dv_den     = d_ext[DIST_W-1:0];
        if (d_ext <= near_ext)
        begin
            fixed_gain = GAIN_ONE;
        end
        else if (d_ext >= far_ext)
        begin
            fixed_gain = '0;
        end
        else
        begin
            case (model_reg)
                MODEL_NONE:   fixed_gain = GAIN_ONE;
                MODEL_LINEAR:
                begin
                    fixed   = 1'b0;
                    dv_base = q_far - d_ext[DIST_W-1:0];
                    dv_den  = q_far - q_near;
                end
                default:      fixed = 1'b0;
            endcase
        end
    end

    logic              cmp_v_reg;
    logic [DIST_W-1:0] base_reg, den_reg;
    logic [SB2-1:0]    sb_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_v_reg <= 1'b0;
        end
        else
        begin
            cmp_v_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= dv_base;
        den_reg  <= dv_den;
        sb_d_reg <= {d_sat, fixed, fixed_gain, q_vol, q_occ};
    end

    logic              dv_valid;
    logic [QUOT_W-1:0] quot;
    logic [SB2-1:0]    dv_sb;

    sda_div #(.DW(DIST_W), .QW(QUOT_W), .SB_W(SB2)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmp_v_reg),
        .base      (base_reg),
        .divisor   (den_reg),
        .in_sb     (sb_d_reg),
        .out_valid (dv_valid),
        .quotient  (quot),
        .out_sb    (dv_sb)
    );

    // volume products
    logic [DIST_W-1:0] o_dist;
    logic              o_fixed;
    logic [GAIN_W-1:0] o_fgain, o_vol, o_occ, gain;

    always_comb
    begin
        {o_dist, o_fixed, o_fgain, o_vol, o_occ} = dv_sb;
        gain = o_fixed ? o_fgain : {1'b0, quot};
    end

    logic [1:0]          mv_reg;
    logic [2*GAIN_W-1:0] p1_reg;
    logic [3*GAIN_W-1:0] p2;
    logic [DIST_W-1:0]   m_dist_reg, r_dist_reg;
    logic [GAIN_W-1:0]   m_gain_reg, r_gain_reg, m_occ_reg, r_fv_reg;

    assign p2 = p1_reg * m_occ_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= '0;
        end
        else
        begin
            mv_reg <= {mv_reg[0], dv_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg     <= o_vol * gain;
        m_occ_reg  <= o_occ;
        m_dist_reg <= o_dist;
        m_gain_reg <= gain;
        r_fv_reg   <= p2[30 +: GAIN_W];
        r_dist_reg <= m_dist_reg;
        r_gain_reg <= m_gain_reg;
    end

    assign result_valid = mv_reg[1];
    assign distance_out = r_dist_reg;
    assign attenuation  = r_gain_reg;
    assign final_volume = r_fv_reg;

endmodule

FILE: sv/sda_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sda_checker
// Port-level checks of latency and result ranges.
// ----------------------------------------------------------------------------
module sda_checker #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          result_valid,
    input  logic [sda_pkg::DIST_W-1:0]    distance_out,
    input  logic [sda_pkg::GAIN_W-1:0]    attenuation,
    input  logic [sda_pkg::GAIN_W-1:0]    final_volume
);
    import sda_pkg::*;

    localparam int LAT = COORD_WIDTH + 22;
    localparam int CW  = $clog2(LAT + 1);

    logic [CW-1:0] since_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            since_reg <= '0;
        end
        else if (since_reg != CW'(LAT))
        begin
            since_reg <= since_reg + 1'b1;
        end
    end

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (since_reg == CW'(LAT)) |-> (result_valid == $past(start && !busy, LAT)))
        else $error("result strobe out of step with accepted beats");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (attenuation <= GAIN_ONE))
        else $error("attenuation above unity");

    a_volume_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (final_volume <= attenuation))
        else $error("final volume above attenuation");

    a_near_unity: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && distance_out == '0) |-> (attenuation == GAIN_ONE))
        else $error("zero distance without unity gain");

endmodule

bind source_distance_attenuation sda_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sda_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .distance_out (distance_out),
    .attenuation  (attenuation),
    .final_volume (final_volume)
);
